// ===== design/bounded_deque_list_assert.svh =====
// ----------------------------------------------------------------------------
// bounded_deque_list_assert.svh
// Assertion macros used by the deque datapath (clock clk, reset arst_n).
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_LIST_ASSERT_SVH
`define BOUNDED_DEQUE_LIST_ASSERT_SVH

// Same-cycle implication: when trig holds, cond must hold.
`define BDL_ASSERT_NOW(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("bounded_deque_list: same-cycle check failed");

// Next-cycle implication: when trig holds, cond must hold in the next cycle.
`define BDL_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("bounded_deque_list: next-cycle check failed");

`endif

// ===== design/bdl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdl_pkg
// Sizes, request and status codes and the controller/datapath interface
// types of the bounded deque.
// ----------------------------------------------------------------------------
package bdl_pkg;

	// Storage geometry (CAPACITY is a power of two: pointers wrap by masking)
	localparam int CAPACITY   = 256;
	localparam int ENTRY_BITS = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 8;
	localparam int FUNC_W     = 3;
	localparam int STATUS_W   = 2;

	// Request codes
	typedef enum logic [FUNC_W-1:0] {
		FN_INS_HEAD = 3'd0,
		FN_INS_TAIL = 3'd1,
		FN_REM_HEAD = 3'd2,
		FN_REM_TAIL = 3'd3,
		FN_RD_HEAD  = 3'd4,
		FN_RD_TAIL  = 3'd5,
		FN_RD_INDEX = 3'd6
	} func_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Read address source
	typedef enum logic [1:0] {
		RS_HEAD  = 2'd0,
		RS_TAIL  = 2'd1,
		RS_INDEX = 2'd2
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    push_head;
		logic    push_tail;
		logic    pop_head;
		logic    pop_tail;
		logic    rd_en;
		rd_sel_t rd_sel;
		status_t status;
	} bdl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic idx_oob;
	} bdl_flags_t;

endpackage

// ===== design/bdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdl_ctrl
// Request decoder and result-slot state machine of the bounded deque.
// ----------------------------------------------------------------------------
module bdl_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bdl_pkg::FUNC_W-1:0]  func,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  bdl_pkg::bdl_flags_t         flags,
	output bdl_pkg::bdl_cmd_t           cmd
);
	import bdl_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   load;
	func_t  fn;

	// Take a request when the result slot is empty or drains this cycle
	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = (state_q == S_RESP);
	assign fn        = func_t'(func);

	// Decode the request against the list flags
	always_comb begin
		cmd        = '0;
		cmd.load   = load;
		cmd.status = ST_OK;
		cmd.rd_sel = RS_HEAD;
		unique case (fn)
			FN_INS_HEAD, FN_INS_TAIL: begin
				if (flags.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.push_head = load && (fn == FN_INS_HEAD);
					cmd.push_tail = load && (fn == FN_INS_TAIL);
				end
			end
			FN_REM_HEAD, FN_REM_TAIL: begin
				if (flags.empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.pop_head = load && (fn == FN_REM_HEAD);
					cmd.pop_tail = load && (fn == FN_REM_TAIL);
				end
			end
			FN_RD_HEAD, FN_RD_TAIL: begin
				cmd.rd_sel = (fn == FN_RD_HEAD) ? RS_HEAD : RS_TAIL;
				if (flags.empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.rd_en = load;
				end
			end
			FN_RD_INDEX: begin
				cmd.rd_sel = RS_INDEX;
				if (flags.empty) begin
					cmd.status = ST_EMPTY;
				end else if (flags.idx_oob) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.rd_en = load;
				end
			end
			default: begin
				// undefined code: no change, status ok
				cmd.status = ST_OK;
			end
		endcase
	end

	// Hold a result until its transfer, refill on a new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			if (load) begin
				state_q <= S_RESP;
			end else if (out_ready) begin
				state_q <= S_IDLE;
			end
		end
	end

endmodule

// ===== design/bdl_dpath.sv =====
// ----------------------------------------------------------------------------
// bdl_dpath
// Circular entry store, head pointer, entry count and result registers.
// ----------------------------------------------------------------------------
`include "bounded_deque_list_assert.svh"

module bdl_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bdl_pkg::bdl_cmd_t               cmd,
	input  logic [bdl_pkg::ENTRY_BITS-1:0]  entry_value,
	input  logic [bdl_pkg::POS_W-1:0]       position_index,
	output bdl_pkg::bdl_flags_t             flags,
	output logic [bdl_pkg::ENTRY_BITS-1:0]  read_value,
	output logic [bdl_pkg::CNT_W-1:0]       list_size,
	output logic [bdl_pkg::STATUS_W-1:0]    status
);
	import bdl_pkg::*;

	logic [ENTRY_BITS-1:0] mem [CAPACITY];
	logic [ENTRY_BITS-1:0] rd_data_q;
	logic                  rd_ok_q;
	status_t               status_q;
	logic [ADDR_W-1:0]     head_q;
	logic [CNT_W-1:0]      count_q;

	logic [ADDR_W-1:0]     head_m1;
	logic [ADDR_W-1:0]     tail_wr;
	logic [ADDR_W-1:0]     tail_rd;
	logic [ADDR_W-1:0]     idx_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;

	// Flags for the decoder
	assign flags.empty   = (count_q == '0);
	assign flags.full    = (count_q == CNT_W'(CAPACITY));
	assign flags.idx_oob = (CNT_W'(position_index) >= count_q);

	// Slot addresses, wrapping modulo the capacity
	assign head_m1  = head_q - 1'b1;
	assign tail_wr  = head_q + count_q[ADDR_W-1:0];
	assign tail_rd  = tail_wr - 1'b1;
	assign idx_addr = head_q + ADDR_W'(position_index);
	assign wr_addr  = cmd.push_head ? head_m1 : tail_wr;

	always_comb begin
		unique case (cmd.rd_sel)
			RS_HEAD:  rd_addr = head_q;
			RS_TAIL:  rd_addr = tail_rd;
			RS_INDEX: rd_addr = idx_addr;
			default:  rd_addr = head_q;
		endcase
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.push_head || cmd.push_tail) begin
			mem[wr_addr] <= entry_value;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Capture result status
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_ok_q  <= cmd.rd_en;
			status_q <= cmd.status;
		end
	end

	// Advance head pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_head) begin
				head_q <= head_m1;
			end else if (cmd.pop_head) begin
				head_q <= head_q + 1'b1;
			end
			if (cmd.push_head || cmd.push_tail) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_head || cmd.pop_tail) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign read_value = rd_ok_q ? rd_data_q : '0;
	assign list_size  = count_q;
	assign status     = status_q;

	`BDL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`BDL_ASSERT_NOW(a_no_push_full, flags.full, !(cmd.push_head || cmd.push_tail))
	`BDL_ASSERT_NEXT(a_push_grows, cmd.push_head || cmd.push_tail,
		count_q == $past(count_q) + 1'b1)
	`BDL_ASSERT_NEXT(a_pop_shrinks, cmd.pop_head || cmd.pop_tail,
		count_q == $past(count_q) - 1'b1)

endmodule

// ===== design/bounded_deque_list.sv =====
// Latency: a result is offered on the cycle after its request transfers.
// Throughput: one request per cycle unless out_ready stalls; the single-port
// entry store does one access per request; results drain as the next loads.
// Reset (arst_n low, asynchronous): list empty, head pointer zero, no result
// pending; the entry store itself is not cleared.
// ----------------------------------------------------------------------------
// bounded_deque_list
// Bounded double-ended queue over a circular entry store, with head/tail
// insert and remove and head, tail or indexed reads.
// ----------------------------------------------------------------------------
module bounded_deque_list (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bdl_pkg::FUNC_W-1:0]      func,
	input  logic [bdl_pkg::ENTRY_BITS-1:0]  entry_value,
	input  logic [bdl_pkg::POS_W-1:0]       position_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bdl_pkg::ENTRY_BITS-1:0]  read_value,
	output logic [bdl_pkg::CNT_W-1:0]       list_size,
	output logic [bdl_pkg::STATUS_W-1:0]    status
);
	import bdl_pkg::*;

	bdl_cmd_t   cmd;
	bdl_flags_t flags;

	// Decode requests and track the result slot
	bdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// Hold the entries and the result
	bdl_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.entry_value    (entry_value),
		.position_index (position_index),
		.flags          (flags),
		.read_value     (read_value),
		.list_size      (list_size),
		.status         (status)
	);

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_deque_list. A shadow circular buffer
// predicts the result of every request at its transfer. Each result is
// compared field by field with the oldest prediction. Directed tests cover
// the empty list and both ends. Longer tests fill the list to capacity,
// drain it, and then run random request mixes, with random gaps on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bdl_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNDEFINED = 3'd7;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 100;

	typedef struct {
		logic [ENTRY_BITS-1:0] read_value;
		logic [CNT_W-1:0]      list_size;
		status_t               status;
	} deque_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func = '0;
	logic [ENTRY_BITS-1:0] entry_value = '0;
	logic [POS_W-1:0]      position_index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ENTRY_BITS-1:0] read_value;
	logic [CNT_W-1:0]      list_size;
	logic [STATUS_W-1:0]   status;

	// Shadow copy of the deque
	logic [ENTRY_BITS-1:0] shadow_store [CAPACITY];
	logic [ADDR_W-1:0]     shadow_head = '0;
	logic [CNT_W-1:0]      shadow_count = '0;

	deque_result_t expected_results [$];
	int mismatch_count = 0;
	int sink_hold = 0;
	bit idle_on = 1'b1;

	bounded_deque_list i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.entry_value    (entry_value),
		.position_index (position_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_value     (read_value),
		.list_size      (list_size),
		.status         (status)
	);

	always #6 clk = ~clk;

	// Apply one request to the shadow deque and return its result
	function automatic deque_result_t apply_deque_request(input logic [FUNC_W-1:0] f,
			input logic [ENTRY_BITS-1:0] v, input logic [POS_W-1:0] p);
		deque_result_t res;
		logic [ADDR_W-1:0] slot;
		res.read_value = '0;
		res.status = ST_OK;
		case (f)
			FN_INS_HEAD: begin
				if (shadow_count >= CAPACITY)
					res.status = ST_FULL;
				else begin
					shadow_head = shadow_head - 1'b1;
					shadow_store[shadow_head] = v;
					shadow_count++;
				end
			end
			FN_INS_TAIL: begin
				if (shadow_count >= CAPACITY)
					res.status = ST_FULL;
				else begin
					slot = shadow_head + shadow_count[ADDR_W-1:0];
					shadow_store[slot] = v;
					shadow_count++;
				end
			end
			FN_REM_HEAD: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				else begin
					shadow_head = shadow_head + 1'b1;
					shadow_count--;
				end
			end
			FN_REM_TAIL: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				else
					shadow_count--;
			end
			FN_RD_HEAD: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				else
					res.read_value = shadow_store[shadow_head];
			end
			FN_RD_TAIL: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				else begin
					slot = shadow_head + shadow_count[ADDR_W-1:0] - 1'b1;
					res.read_value = shadow_store[slot];
				end
			end
			FN_RD_INDEX: begin
				if (shadow_count == 0)
					res.status = ST_EMPTY;
				else if (CNT_W'(p) >= shadow_count)
					res.status = ST_RANGE;
				else begin
					slot = shadow_head + p;
					res.read_value = shadow_store[slot];
				end
			end
			default: ;
		endcase
		res.list_size = shadow_count;
		return res;
	endfunction

	// Mostly short gaps, a few long ones; none while idling is off
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 70)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	function automatic logic [ENTRY_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return $urandom;
	endfunction

	// Mostly in-range positions, sometimes any position
	function automatic logic [POS_W-1:0] pick_index();
		if (shadow_count > 0 && $urandom_range(0, 3) != 0)
			return POS_W'($urandom_range(0, shadow_count - 1));
		else
			return POS_W'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Offer one request, hold it until the transfer, then predict its result
	task automatic send_request(input logic [FUNC_W-1:0] f,
			input logic [ENTRY_BITS-1:0] v, input logic [POS_W-1:0] p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_value <= v;
		position_index <= p;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(apply_deque_request(f, v, p));
	endtask

	task automatic send_random_read();
		case ($urandom_range(0, 2))
			0: send_request(FN_RD_HEAD, $urandom, POS_W'($urandom));
			1: send_request(FN_RD_TAIL, $urandom, POS_W'($urandom));
			default: send_request(FN_RD_INDEX, $urandom, pick_index());
		endcase
	endtask

	// Every remove and read request on an empty list, plus the undefined code
	task automatic test_empty_list();
		send_request(FN_REM_HEAD, '1, '0);
		send_request(FN_REM_TAIL, '0, '1);
		send_request(FN_RD_HEAD, '0, '0);
		send_request(FN_RD_TAIL, '1, '1);
		send_request(FN_RD_INDEX, '0, 8'd0);
		send_request(FN_RD_INDEX, '1, 8'd255);
		send_request(FN_UNDEFINED, '1, '1);
	endtask

	// Insert at both ends across the pointer wrap, read back, remove
	task automatic test_ends_and_index();
		send_request(FN_INS_TAIL, 32'h0000_0000, '0);
		send_request(FN_INS_HEAD, 32'hFFFF_FFFF, '1);
		send_request(FN_INS_TAIL, 32'hA5A5_A5A5, '0);
		send_request(FN_INS_HEAD, 32'h5A5A_5A5A, '1);
		send_request(FN_RD_HEAD, '0, '0);
		send_request(FN_RD_TAIL, '0, '0);
		send_request(FN_RD_INDEX, '0, 8'd0);
		send_request(FN_RD_INDEX, '0, 8'd3);
		send_request(FN_RD_INDEX, '0, 8'd4);
		send_request(FN_RD_INDEX, '0, 8'd255);
		send_request(FN_REM_HEAD, '0, '0);
		send_request(FN_REM_TAIL, '0, '0);
		send_request(FN_RD_HEAD, '0, '0);
		send_request(FN_RD_TAIL, '0, '0);
		send_request(FN_REM_TAIL, '0, '0);
		send_request(FN_REM_HEAD, '0, '0);
		send_request(FN_REM_HEAD, '0, '0);
		send_request(FN_UNDEFINED, 32'h1234_5678, 8'h80);
	endtask

	// Fill to capacity, then push against the full list and read it
	task automatic test_fill_to_capacity();
		idle_on = 1'b1;
		while (shadow_count < CAPACITY) begin
			if ($urandom_range(0, 9) == 0)
				send_random_read();
			else if ($urandom_range(0, 1))
				send_request(FN_INS_TAIL, pick_value(), POS_W'($urandom));
			else
				send_request(FN_INS_HEAD, pick_value(), POS_W'($urandom));
		end
		send_request(FN_INS_HEAD, pick_value(), '0);
		send_request(FN_INS_TAIL, pick_value(), '0);
		send_request(FN_RD_INDEX, '0, 8'd255);
		send_request(FN_RD_INDEX, '0, 8'd0);
		send_request(FN_RD_HEAD, '0, '0);
		send_request(FN_RD_TAIL, '0, '0);
		repeat (8) send_random_read();
	endtask

	// Drain back-to-back with no idling, then remove from the empty list
	task automatic test_drain();
		idle_on = 1'b0;
		while (shadow_count > 0) begin
			if ($urandom_range(0, 99) < 15)
				send_random_read();
			else if ($urandom_range(0, 1))
				send_request(FN_REM_HEAD, $urandom, POS_W'($urandom));
			else
				send_request(FN_REM_TAIL, $urandom, POS_W'($urandom));
		end
		send_request(FN_REM_HEAD, '0, '0);
		send_request(FN_REM_TAIL, '0, '0);
		idle_on = 1'b1;
	endtask

	// Segments of random requests, each with its own bias and idling mode
	task automatic test_random_mix(input int n_items);
		int sent, seg_len, ins_w, rem_w, r;
		logic [FUNC_W-1:0] f;
		sent = 0;
		while (sent < n_items) begin
			seg_len = $urandom_range(40, 160);
			case ($urandom_range(0, 3))
				0: begin ins_w = 70; rem_w = 15; end
				1: begin ins_w = 15; rem_w = 70; end
				2: begin ins_w = 40; rem_w = 40; end
				default: begin ins_w = 20; rem_w = 20; end
			endcase
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (seg_len) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					f = FN_UNDEFINED;
				else if (r < 2 + ins_w)
					f = $urandom_range(0, 1) ? FN_INS_TAIL : FN_INS_HEAD;
				else if (r < 2 + ins_w + rem_w)
					f = $urandom_range(0, 1) ? FN_REM_TAIL : FN_REM_HEAD;
				else
					case ($urandom_range(0, 2))
						0: f = FN_RD_HEAD;
						1: f = FN_RD_TAIL;
						default: f = FN_RD_INDEX;
					endcase
				send_request(f, pick_value(), pick_index());
				sent++;
			end
		end
		idle_on = 1'b1;
	endtask

	// Stall the result side at random
	always @(posedge clk) begin
		if (sink_hold == 0)
			sink_hold = pick_gap();
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold--;
		end else
			out_ready <= 1'b1;
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0)
				report_mismatch("result transfer with no request pending");
			else begin
				want = expected_results.pop_front();
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value %h, expected %h",
						read_value, want.read_value));
				if (list_size !== want.list_size)
					report_mismatch($sformatf("list_size %0d, expected %0d",
						list_size, want.list_size));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
			end
		end
	end

	// End the run when no transfer happens for too long
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_ends_and_index();
		test_fill_to_capacity();
		test_drain();
		test_random_mix(1150);

		// Drop valid, wait out the remaining results, then idle before the verdict
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/bdl_pkg.sv
design/bdl_ctrl.sv
design/bdl_dpath.sv
design/bounded_deque_list.sv
tb/testbench.sv
